// File: src/bsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the best-screen select and clamp unit.
// No dependencies; used by bsc_scan, bsc_clamp and the top level by scoped names.
package bsc_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_LOAD_BOUNDS = 2'd0,
      KIND_LOAD_AREA   = 2'd1,
      KIND_QUERY       = 2'd2
   } kind_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_SCREEN_COUNT = 2'd0;
   localparam logic [1:0] CSR_ROOT_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_ROOT_HEIGHT  = 2'd2;
   localparam logic [1:0] CSR_FALLBACK_TOP = 2'd3;

   // Register reset values
   localparam logic [3:0]  SCREEN_COUNT_RESET = 4'd0;
   localparam logic [14:0] ROOT_WIDTH_RESET   = 15'd1024;
   localparam logic [14:0] ROOT_HEIGHT_RESET  = 15'd768;
   localparam logic [11:0] FALLBACK_TOP_RESET = 12'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AREA_RD,
      ST_CLAMP
   } state_type;

   // One stored rectangle, as kept in the screen tables
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
   } rect_type;

   // Window geometry of the query in flight, with its precomputed centre
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
      logic signed [16:0] cx;
      logic signed [16:0] cy;
   } query_type;

   typedef struct packed {
      logic [11:0] left;
      logic [11:0] right;
      logic [11:0] top;
      logic [11:0] bottom;
   } margin_type;

   typedef struct packed {
      logic busy;
      logic found;
   } scan_status_type;

endpackage

// File: src/bsc_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsc_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bsc_scan.sv
`timescale 1ns / 1ps
// Screen selection pipeline: overlap and centre distance per bounds beat,
// then running best. Depends on bsc_pkg.
module bsc_scan #(
   parameter int MAX_SCREENS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       rd_vld,
   input  logic [((MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1)-1:0] rd_idx,
   input  bsc_pkg::rect_type          bounds,
   input  bsc_pkg::query_type         query,
   output bsc_pkg::scan_status_type   status,
   output logic [((MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1)-1:0] best_idx
);

   localparam int AW = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;

   logic signed [17:0] bx, by, br, bb, br1, bb1;
   logic signed [17:0] qx, qy, qr, qb, cx, cy;
   logic signed [17:0] il, it, ir, ib;
   logic [16:0]        ow_in, oh_in, dx_in, dy_in;
   logic [16:0]        ow_ff, oh_ff, dx_ff, dy_ff;
   logic [AW-1:0]      idx1_ff, idx2_ff;
   logic               s1v_ff, s2v_ff;
   logic [33:0]        ov_ff, dx2_ff, dy2_ff;
   logic [34:0]        d2_sum;
   logic               take;
   logic               found_ff, found_in;
   logic [33:0]        best_ov_ff, best_ov_in;
   logic [34:0]        best_d_ff, best_d_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;

   // Stage 1: intersection extents and centre distance per axis
   always_comb begin
      bx  = 18'(bounds.x);
      by  = 18'(bounds.y);
      br  = bx + $signed({3'b0, bounds.w});
      bb  = by + $signed({3'b0, bounds.h});
      br1 = br - 18'sd1;
      bb1 = bb - 18'sd1;
      qx  = 18'(query.x);
      qy  = 18'(query.y);
      qr  = qx + $signed({3'b0, query.w});
      qb  = qy + $signed({3'b0, query.h});
      cx  = 18'(query.cx);
      cy  = 18'(query.cy);
      il  = (bx > qx) ? bx : qx;
      it  = (by > qy) ? by : qy;
      ir  = (br < qr) ? br : qr;
      ib  = (bb < qb) ? bb : qb;
      // an empty extent on either axis zeroes the product
      ow_in = (ir > il) ? 17'(ir - il) : '0;
      oh_in = (ib > it) ? 17'(ib - it) : '0;
      if (cx < bx) begin
         dx_in = 17'(bx - cx);
      end else if (cx > br1) begin
         dx_in = 17'(cx - br1);
      end else begin
         dx_in = '0;
      end
      if (cy < by) begin
         dy_in = 17'(by - cy);
      end else if (cy > bb1) begin
         dy_in = 17'(cy - bb1);
      end else begin
         dy_in = '0;
      end
   end

   // Stage 3: running best, first slot wins full ties
   always_comb begin
      d2_sum = {1'b0, dx2_ff} + {1'b0, dy2_ff};
      take = !found_ff || (ov_ff > best_ov_ff) ||
             ((ov_ff == best_ov_ff) && (d2_sum < best_d_ff));
      found_in    = found_ff;
      best_ov_in  = best_ov_ff;
      best_d_in   = best_d_ff;
      best_idx_in = best_idx_ff;
      if (start) begin
         found_in    = 1'b0;
         best_idx_in = '0;
      end else if (s2v_ff && take) begin
         found_in    = 1'b1;
         best_ov_in  = ov_ff;
         best_d_in   = d2_sum;
         best_idx_in = idx2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff      <= 1'b0;
         s2v_ff      <= 1'b0;
         found_ff    <= 1'b0;
         best_idx_ff <= '0;
      end else begin
         s1v_ff      <= rd_vld;
         s2v_ff      <= s1v_ff;
         found_ff    <= found_in;
         best_idx_ff <= best_idx_in;
      end
      ow_ff      <= ow_in;
      oh_ff      <= oh_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      idx1_ff    <= rd_idx;
      // Stage 2: products
      ov_ff      <= ow_ff * oh_ff;
      dx2_ff     <= dx_ff * dx_ff;
      dy2_ff     <= dy_ff * dy_ff;
      idx2_ff    <= idx1_ff;
      best_ov_ff <= best_ov_in;
      best_d_ff  <= best_d_in;
   end

   assign status.busy  = s1v_ff || s2v_ff;
   assign status.found = found_ff;
   assign best_idx     = best_idx_ff;

endmodule

// File: src/bsc_clamp.sv
`timescale 1ns / 1ps
// Clamp of the preferred window position into a work area shrunk by the
// frame margins. Combinational; depends on bsc_pkg.
module bsc_clamp (
   input  bsc_pkg::rect_type   area,
   input  bsc_pkg::query_type  query,
   input  bsc_pkg::margin_type margin,
   output logic signed [17:0]  pos_x,
   output logic signed [17:0]  pos_y
);

   logic signed [17:0] lo_x, hi_x, lo_y, hi_y, pref_x, pref_y;

   always_comb begin
      pref_x = 18'(query.x);
      pref_y = 18'(query.y);
      lo_x = 18'(area.x) + $signed({6'b0, margin.left});
      hi_x = 18'(area.x) + $signed({3'b0, area.w}) - $signed({3'b0, query.w})
             - $signed({6'b0, margin.right});
      lo_y = 18'(area.y) + $signed({6'b0, margin.top});
      hi_y = 18'(area.y) + $signed({3'b0, area.h}) - $signed({3'b0, query.h})
             - $signed({6'b0, margin.bottom});
      // an empty range falls back to the minimum
      if (hi_x < lo_x || pref_x < lo_x) begin
         pos_x = lo_x;
      end else if (pref_x > hi_x) begin
         pos_x = hi_x;
      end else begin
         pos_x = pref_x;
      end
      if (hi_y < lo_y || pref_y < lo_y) begin
         pos_y = lo_y;
      end else if (pref_y > hi_y) begin
         pos_y = hi_y;
      end else begin
         pos_y = pref_y;
      end
   end

endmodule

// File: src/best_screen_select_and_clamp_unit.sv
`timescale 1ns / 1ps
// Top level of the best-screen select and clamp unit.
// Depends on bsc_pkg, bsc_ram, bsc_scan and bsc_clamp.

// Load beats write one rectangle into the bounds or work-area table; they give
// no response. A query beat walks the first min(screen_count, MAX_SCREENS)
// slots of the bounds table, one synchronous RAM read per cycle feeding a
// three-stage overlap/distance pipeline, then reads the chosen work area (the
// root area when no screen is found) and clamps. A query occupies the block
// through the bounds RAM walk, the pipeline drain, the work-area read and the
// clamp. The result sits in an output register, so the next beat is taken
// while it waits; a query that reaches the clamp step while the previous
// result still waits holds there.
// Table contents are undefined until loaded; configure only while idle.
module best_screen_select_and_clamp_unit #(
   parameter int MAX_SCREENS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_slot,
   input  logic signed [15:0] req_rect_x,
   input  logic signed [15:0] req_rect_y,
   input  logic [14:0]        req_rect_w,
   input  logic [14:0]        req_rect_h,
   input  logic               req_frame_valid,
   input  logic [11:0]        req_frame_left,
   input  logic [11:0]        req_frame_right,
   input  logic [11:0]        req_frame_top,
   input  logic [11:0]        req_frame_bottom,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [17:0] rsp_pos_x,
   output logic signed [17:0] rsp_pos_y,
   output logic               rsp_screen_found,
   output logic [2:0]         rsp_screen_index,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_wdata
);

   localparam int AW = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
   localparam int CW = $clog2(MAX_SCREENS + 1);
   localparam int RW = $bits(bsc_pkg::rect_type);

   bsc_pkg::state_type       state_ff, state_in;
   logic [3:0]               count_ff, count_in;
   logic [14:0]              root_w_ff, root_w_in;
   logic [14:0]              root_h_ff, root_h_in;
   logic [11:0]              ftop_ff, ftop_in;
   bsc_pkg::query_type       query_ff, query_in;
   bsc_pkg::margin_type      margin_ff, margin_in;
   logic [CW-1:0]            lim_ff, lim_in, lim_new;
   logic [CW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     rd_vld_ff;
   logic [AW-1:0]            rd_slot_ff;
   logic                     accept, is_query, slot_ok;
   logic                     bnd_we, area_we, bnd_rd_en, area_rd_en;
   logic                     scan_start, scan_done, rsp_free, rsp_load;
   bsc_pkg::rect_type        wr_rect, bnd_rdata, area_rdata, area_sel;
   bsc_pkg::scan_status_type scan_st;
   logic [AW-1:0]            best_idx;
   logic signed [17:0]       clamp_x, clamp_y;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [17:0]       rsp_x_ff, rsp_y_ff;
   logic                     rsp_found_ff;
   logic [2:0]               rsp_idx_ff;

   // ---------------- configuration registers ----------------
   always_comb begin
      count_in  = count_ff;
      root_w_in = root_w_ff;
      root_h_in = root_h_ff;
      ftop_in   = ftop_ff;
      if (csr_we) begin
         case (csr_index)
            bsc_pkg::CSR_SCREEN_COUNT: count_in  = csr_wdata[3:0];
            bsc_pkg::CSR_ROOT_WIDTH:   root_w_in = csr_wdata;
            bsc_pkg::CSR_ROOT_HEIGHT:  root_h_in = csr_wdata;
            bsc_pkg::CSR_FALLBACK_TOP: ftop_in   = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // ---------------- request decode ----------------
   always_comb begin
      accept   = req_valid && req_ready;
      is_query = (req_kind == bsc_pkg::KIND_QUERY);
      slot_ok  = ({29'b0, req_slot} < 32'(MAX_SCREENS));
      bnd_we   = accept && slot_ok && (req_kind == bsc_pkg::KIND_LOAD_BOUNDS);
      area_we  = accept && slot_ok && (req_kind == bsc_pkg::KIND_LOAD_AREA);
      wr_rect.x = req_rect_x;
      wr_rect.y = req_rect_y;
      wr_rect.w = req_rect_w;
      wr_rect.h = req_rect_h;
      if ({28'b0, count_ff} > 32'(MAX_SCREENS)) begin
         lim_new = CW'(MAX_SCREENS);
      end else begin
         lim_new = CW'(count_ff);
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      scan_done = (rd_idx_ff == lim_ff) && !rd_vld_ff && !scan_st.busy;
      rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (req_valid && is_query) state_in = bsc_pkg::ST_SCAN;
         end
         bsc_pkg::ST_SCAN: begin
            if (scan_done) state_in = bsc_pkg::ST_AREA_RD;
         end
         bsc_pkg::ST_AREA_RD: begin
            state_in = bsc_pkg::ST_CLAMP;
         end
         bsc_pkg::ST_CLAMP: begin
            if (rsp_free) state_in = bsc_pkg::ST_IDLE;
         end
         default: state_in = bsc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      scan_start = 1'b0;
      bnd_rd_en  = 1'b0;
      area_rd_en = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         bsc_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            scan_start = req_valid && is_query;
         end
         bsc_pkg::ST_SCAN: begin
            bnd_rd_en = (rd_idx_ff < lim_ff);
         end
         bsc_pkg::ST_AREA_RD: begin
            area_rd_en = scan_st.found;
         end
         bsc_pkg::ST_CLAMP: begin
            rsp_load = rsp_free;
         end
         default: ;
      endcase
   end

   // ---------------- query context ----------------
   always_comb begin
      query_in  = query_ff;
      margin_in = margin_ff;
      lim_in    = lim_ff;
      rd_idx_in = rd_idx_ff;
      if (scan_start) begin
         query_in.x  = req_rect_x;
         query_in.y  = req_rect_y;
         query_in.w  = req_rect_w;
         query_in.h  = req_rect_h;
         query_in.cx = 17'(req_rect_x) + $signed({3'b0, req_rect_w[14:1]});
         query_in.cy = 17'(req_rect_y) + $signed({3'b0, req_rect_h[14:1]});
         if (req_frame_valid) begin
            margin_in.left   = req_frame_left;
            margin_in.right  = req_frame_right;
            margin_in.top    = req_frame_top;
            margin_in.bottom = req_frame_bottom;
         end else begin
            margin_in.left   = '0;
            margin_in.right  = '0;
            margin_in.top    = ftop_ff;
            margin_in.bottom = '0;
         end
         lim_in    = lim_new;
         rd_idx_in = '0;
      end else if (bnd_rd_en) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (scan_st.found) begin
         area_sel = area_rdata;
      end else begin
         area_sel.x = '0;
         area_sel.y = '0;
         area_sel.w = root_w_ff;
         area_sel.h = root_h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsc_pkg::ST_IDLE;
         count_ff     <= bsc_pkg::SCREEN_COUNT_RESET;
         root_w_ff    <= bsc_pkg::ROOT_WIDTH_RESET;
         root_h_ff    <= bsc_pkg::ROOT_HEIGHT_RESET;
         ftop_ff      <= bsc_pkg::FALLBACK_TOP_RESET;
         rd_idx_ff    <= '0;
         lim_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         root_w_ff    <= root_w_in;
         root_h_ff    <= root_h_in;
         ftop_ff      <= ftop_in;
         rd_idx_ff    <= rd_idx_in;
         lim_ff       <= lim_in;
         rd_vld_ff    <= bnd_rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
      // slot number that travels with the bounds beat out of the RAM
      rd_slot_ff <= rd_idx_ff[AW-1:0];
      query_ff   <= query_in;
      margin_ff  <= margin_in;
      if (rsp_load) begin
         rsp_x_ff     <= clamp_x;
         rsp_y_ff     <= clamp_y;
         rsp_found_ff <= scan_st.found;
         rsp_idx_ff   <= scan_st.found ? 3'(best_idx) : 3'd0;
      end
   end

   // ---------------- instances ----------------
   bsc_ram #(.WIDTH(RW), .DEPTH(MAX_SCREENS), .AW(AW)) u_bounds_ram (
      .clock   (clock),
      .wr_en   (bnd_we),
      .wr_addr (AW'(req_slot)),
      .wr_data (wr_rect),
      .rd_en   (bnd_rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (bnd_rdata)
   );

   bsc_ram #(.WIDTH(RW), .DEPTH(MAX_SCREENS), .AW(AW)) u_area_ram (
      .clock   (clock),
      .wr_en   (area_we),
      .wr_addr (AW'(req_slot)),
      .wr_data (wr_rect),
      .rd_en   (area_rd_en),
      .rd_addr (best_idx),
      .rd_data (area_rdata)
   );

   bsc_scan #(.MAX_SCREENS(MAX_SCREENS)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .rd_vld   (rd_vld_ff),
      .rd_idx   (rd_slot_ff),
      .bounds   (bnd_rdata),
      .query    (query_ff),
      .status   (scan_st),
      .best_idx (best_idx)
   );

   bsc_clamp u_clamp (
      .area   (area_sel),
      .query  (query_ff),
      .margin (margin_ff),
      .pos_x  (clamp_x),
      .pos_y  (clamp_y)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = rsp_x_ff;
   assign rsp_pos_y        = rsp_y_ff;
   assign rsp_screen_found = rsp_found_ff;
   assign rsp_screen_index = rsp_idx_ff;

   // ---------------- assertions ----------------
   a_rsp_from_clamp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bsc_pkg::ST_CLAMP))
      else $error("response raised outside clamp step");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rd_vld_ff && !scan_st.busy))
      else $error("ready while selection pipeline still busy");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      bnd_rd_en |-> (rd_idx_ff < lim_ff))
      else $error("bounds read past screen count");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (bnd_we || area_we) |-> (state_ff == bsc_pkg::ST_IDLE))
      else $error("table write while a query is in flight");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_idx_ff == 3'd0))
      else $error("screen index set with no screen found");

endmodule
